// File: rtl/ssc_pkg.sv
package ssc_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_SPRITE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;

  // Command codes handed from the front end to the back end.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_ZERO  = 2'd2;

  // Pixel width and the widest line address (line width up to 1024).
  localparam int PIXEL_W    = 16;
  localparam int MAX_ADDR_W = 10;

  // Defaults for the top-level parameters.
  localparam int DEF_LINE_WIDTH  = 128;
  localparam int DEF_QUEUE_DEPTH = 2;

  // One classified beat for the back end.
  typedef struct packed {
    logic [1:0]            kind;
    logic [MAX_ADDR_W-1:0] addr;
    logic [PIXEL_W-1:0]    data;
  } cmd_t;

endpackage

// File: rtl/ssc_ram.sv
module ssc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port with a registered read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ssc_front.sv
module ssc_front
  import ssc_pkg::*;
#(
  parameter int LINE_WIDTH = DEF_LINE_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              beat_ok,
  input  logic [1:0]        op,
  input  logic signed [8:0] sprite_x,
  input  logic signed [8:0] sprite_y,
  input  logic [7:0]        sprite_width,
  input  logic [7:0]        sprite_height,
  input  logic              visible,
  input  logic              mirror,
  input  logic [6:0]        scanline,
  input  logic [6:0]        src_column,
  input  logic [15:0]       color,
  input  logic [6:0]        line_addr,
  output logic              push,
  output cmd_t              push_cmd
);

  localparam logic [10:0] LINE_LIM = 11'(LINE_WIDTH);

  logic [15:0]       key_r;
  logic [15:0]       key_nxt;
  logic signed [9:0] row;
  logic signed [10:0] ofs;
  logic signed [10:0] tx;
  logic              row_hit;
  logic              col_hit;
  logic              tx_hit;
  logic              spr_draw;
  logic [10:0]       la_ext;
  logic              la_hit;
  logic              keep;

  // Transparent color key register.
  always_comb begin
    key_nxt = key_r;
    if (cfg_we) begin
      key_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // Sprite pixel placement and clipping.
  always_comb begin
    row     = $signed({3'b000, scanline}) - 10'(sprite_y);
    row_hit = !row[9] && ({1'b0, row[8:0]} < {2'b00, sprite_height});
    col_hit = {1'b0, src_column} < sprite_width;
    if (mirror) begin
      ofs = $signed({3'b000, sprite_width}) - 11'sd1 - $signed({4'b0000, src_column});
    end else begin
      ofs = $signed({4'b0000, src_column});
    end
    tx       = 11'(sprite_x) + ofs;
    tx_hit   = !tx[10] && ({1'b0, tx[9:0]} < LINE_LIM);
    spr_draw = visible && row_hit && col_hit && tx_hit && (color != key_r);
    la_ext   = {4'b0000, line_addr};
    la_hit   = la_ext < LINE_LIM;
  end

  // Classify the beat into a back-end command, dropping beats with no effect.
  always_comb begin
    keep          = 1'b0;
    push_cmd.kind = CMD_WRITE;
    push_cmd.addr = la_ext[MAX_ADDR_W-1:0];
    push_cmd.data = color;
    unique case (op)
      OP_SPRITE: begin
        keep          = spr_draw;
        push_cmd.addr = tx[MAX_ADDR_W-1:0];
      end
      OP_READ: begin
        keep          = 1'b1;
        push_cmd.kind = la_hit ? CMD_READ : CMD_ZERO;
      end
      OP_WRITE: begin
        keep = la_hit;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    push = beat_ok && keep;
  end

endmodule

// File: rtl/ssc_queue.sv
module ssc_queue
  import ssc_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic not_empty
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign rd_cmd    = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// File: rtl/ssc_back.sv
module ssc_back
  import ssc_pkg::*;
#(
  parameter int LINE_WIDTH = DEF_LINE_WIDTH,
  localparam int ADDR_W = $clog2(LINE_WIDTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_avail,
  input  cmd_t               cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIXEL_W-1:0] out_pixel_value
);

  logic               rd_pend_r;
  logic               rd_pend_nxt;
  logic               zero_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [PIXEL_W-1:0] pix_r;
  logic               is_write;
  logic               slot_free;
  logic               ram_en;
  logic               ram_we;
  logic [PIXEL_W-1:0] ram_rdata;

  // A read is issued only when its result will find the output register free.
  always_comb begin
    is_write  = (cmd.kind == CMD_WRITE);
    slot_free = !rd_pend_r && (!out_valid_r || !out_stall);
    pop       = cmd_avail && (is_write || slot_free);
    ram_we    = pop && is_write;
    ram_en    = pop && (cmd.kind != CMD_ZERO);
  end

  ssc_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (LINE_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (cmd.addr[ADDR_W-1:0]),
    .wdata (cmd.data),
    .rdata (ram_rdata)
  );

  // Read tracking and output register control.
  always_comb begin
    rd_pend_nxt   = pop && !is_write;
    out_valid_nxt = out_valid_r;
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload; an off-line read returns zero.
  always_ff @(posedge clk) begin
    if (pop) begin
      zero_r <= (cmd.kind == CMD_ZERO);
    end
    if (rd_pend_r) begin
      pix_r <= zero_r ? '0 : ram_rdata;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = pix_r;

endmodule

// File: rtl/sprite_scanline_compositor_unit.sv
// Path: an accepted read beat passes the command queue, the registered line
// RAM read and the output register. Throughput: one beat per cycle for sprite
// pixels and line writes while in_stall is low; a read waits until the earlier
// read has left the single RAM port and the one-entry output register is free.
// Reset (rst_n, synchronous) clears the color key, the queue and the output;
// line buffer contents are undefined until written.
module sprite_scanline_compositor_unit
  import ssc_pkg::*;
#(
  parameter int LINE_WIDTH  = DEF_LINE_WIDTH,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic signed [8:0] in_sprite_x,
  input  logic signed [8:0] in_sprite_y,
  input  logic [7:0]        in_sprite_width,
  input  logic [7:0]        in_sprite_height,
  input  logic              in_visible,
  input  logic              in_mirror,
  input  logic [6:0]        in_scanline,
  input  logic [6:0]        in_src_column,
  input  logic [15:0]       in_color,
  input  logic [6:0]        in_line_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_pixel_value
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  cmd_t q_head;
  logic q_avail;

  assign in_stall = q_full;

  // Front end: color key, clipping and classification.
  ssc_front #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .beat_ok       (in_valid && !q_full),
    .op            (in_op),
    .sprite_x      (in_sprite_x),
    .sprite_y      (in_sprite_y),
    .sprite_width  (in_sprite_width),
    .sprite_height (in_sprite_height),
    .visible       (in_visible),
    .mirror        (in_mirror),
    .scanline      (in_scanline),
    .src_column    (in_src_column),
    .color         (in_color),
    .line_addr     (in_line_addr),
    .push          (q_push),
    .push_cmd      (q_push_cmd)
  );

  // Command queue between front and back end.
  ssc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_push),
    .wr_cmd    (q_push_cmd),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_cmd    (q_head),
    .not_empty (q_avail)
  );

  // Back end: line buffer access and result register.
  ssc_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_avail       (q_avail),
    .cmd             (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_value (out_pixel_value)
  );

endmodule
